### rtl/ilt_pkg.sv
// shared widths, codes and control types for the indexed list table
`default_nettype none

package ilt_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int ACT_W  = 2;
    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 7;

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/ilt_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/ilt_ctrl.sv
// request sequencer for the indexed list table
`default_nettype none

module ilt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ilt_pkg::t_sts i_sts,
    output ilt_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.walk   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.need_walk ? S_WALK : S_FIN;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hand the result over once the output register has room
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/ilt_dp.sv
// list storage, count, walk pointer and result registers
`default_nettype none

module ilt_dp #(
    parameter int DEPTH = ilt_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ilt_pkg::t_cmd                     i_cmd,
    output ilt_pkg::t_sts                          o_sts,
    input  wire logic [ilt_pkg::ACT_W-1:0]         i_action,
    input  wire logic [ilt_pkg::IDX_W-1:0]         i_index,
    input  wire logic signed [ilt_pkg::DATA_W-1:0] i_value,
    input  wire logic                              i_out_stall,
    output logic                                   o_valid,
    output logic      [ilt_pkg::STAT_W-1:0]        o_status,
    output logic      [ilt_pkg::POS_W-1:0]         o_position,
    output logic      [ilt_pkg::POS_W-1:0]         o_length
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ilt_pkg::IDX_W) ? CW : ilt_pkg::IDX_W;

    // control
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_rptr;
    logic [CW-1:0] n_rptr;
    logic          r_rd_vld;
    logic          n_rd_vld;
    logic          r_out_vld;

    // payload
    logic [ilt_pkg::ACT_W-1:0]         r_act;
    logic signed [ilt_pkg::DATA_W-1:0] r_val;
    logic [ilt_pkg::STAT_W-1:0]        r_res_status;
    logic [ilt_pkg::STAT_W-1:0]        n_res_status;
    logic [ilt_pkg::POS_W-1:0]         r_res_pos;
    logic [ilt_pkg::POS_W-1:0]         n_res_pos;
    logic [ilt_pkg::STAT_W-1:0]        r_o_status;
    logic [ilt_pkg::POS_W-1:0]         r_o_pos;
    logic [ilt_pkg::POS_W-1:0]         r_o_len;

    logic [CMPW-1:0]           idx_c;
    logic                      idx_ok;
    logic                      full;
    logic                      hit;
    logic                      drained;
    logic                      issue;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ilt_pkg::DATA_W-1:0] ram_wdata;
    logic [ilt_pkg::DATA_W-1:0] rd_data;

    assign idx_c  = CMPW'(i_index);
    assign idx_ok = idx_c < CMPW'(r_count);
    assign full   = r_count >= CW'(DEPTH);

    assign hit     = r_rd_vld && (r_act == ilt_pkg::ACT_SEARCH) && (rd_data == r_val);
    assign drained = !r_rd_vld && (r_rptr >= r_count);
    assign issue   = i_cmd.walk && !hit && (r_rptr < r_count);

    assign o_sts.need_walk = (i_action == ilt_pkg::ACT_SEARCH)
                          || ((i_action == ilt_pkg::ACT_DELETE) && idx_ok);
    assign o_sts.walk_done = hit || drained;
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        n_count      = r_count;
        n_rptr       = r_rptr;
        n_rd_vld     = r_rd_vld;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_rptr - CW'(2));
        ram_wdata    = rd_data;
        if (i_cmd.start) begin
            n_rd_vld  = 1'b0;
            n_res_pos = '0;
            n_rptr    = '0;
            unique case (i_action)
                ilt_pkg::ACT_APPEND: begin
                    if (full) begin
                        n_res_status = ilt_pkg::ST_FULL;
                    end else begin
                        n_res_status = ilt_pkg::ST_OK;
                        ram_we       = 1'b1;
                        ram_waddr    = AW'(r_count);
                        ram_wdata    = i_value;
                        n_count      = r_count + CW'(1);
                    end
                end
                ilt_pkg::ACT_DELETE: begin
                    n_res_status = idx_ok ? ilt_pkg::ST_OK : ilt_pkg::ST_BAD_INDEX;
                    n_rptr       = CW'(idx_c + CMPW'(1));
                end
                ilt_pkg::ACT_UPDATE: begin
                    n_res_status = idx_ok ? ilt_pkg::ST_OK : ilt_pkg::ST_BAD_INDEX;
                    if (idx_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(idx_c);
                        ram_wdata = i_value;
                    end
                end
                ilt_pkg::ACT_SEARCH: begin
                    n_res_status = ilt_pkg::ST_NOT_FOUND;
                end
                default: begin
                    n_res_status = ilt_pkg::ST_NOT_FOUND;
                end
            endcase
        end else if (i_cmd.walk) begin
            // read one word ahead; on delete each word read is written one place down
            n_rd_vld = issue;
            if (issue) begin
                n_rptr = r_rptr + CW'(1);
            end
            if ((r_act == ilt_pkg::ACT_DELETE) && r_rd_vld) begin
                ram_we = 1'b1;
            end
            if (hit) begin
                n_res_status = ilt_pkg::ST_OK;
                n_res_pos    = ilt_pkg::POS_W'(r_rptr);
            end
            if (drained && (r_act == ilt_pkg::ACT_DELETE)) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    ilt_ram #(
        .WIDTH (ilt_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (AW'(r_rptr)),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rptr    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rptr   <= n_rptr;
            r_rd_vld <= n_rd_vld;
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        if (i_cmd.start) begin
            r_act <= i_action;
            r_val <= i_value;
        end
        if (i_cmd.finish) begin
            r_o_status <= r_res_status;
            r_o_pos    <= r_res_pos;
            r_o_len    <= ilt_pkg::POS_W'(r_count);
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_o_status;
    assign o_position = r_o_pos;
    assign o_length   = r_o_len;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_o_pos != '0)) |-> (r_o_status == ilt_pkg::ST_OK))
        else $error("search position reported without ok status");

    a_rd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.walk))
        else $error("read data flagged valid outside a walk");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && ram_we) |-> (r_rptr >= CW'(2)) && ((r_rptr - CW'(1)) <= r_count))
        else $error("delete shift writes outside the list");

endmodule

`default_nettype wire

### rtl/indexed_list_table.sv
// indexed_list_table: a compact list of signed 32-bit words with append,
// delete-at-index, update-at-index and search requests.
// Request channel: i_valid with i_action, i_index, i_value; a transfer
// happens at an edge where i_valid is high and o_stall is low. o_stall is
// high while a request is being worked on.
// Result channel: o_valid with o_status, o_position, o_length; a transfer
// happens at an edge where o_valid is high and i_stall is low.
// Append, update and rejected requests skip the walk and go straight to
// the result. Delete at index k walks the words above k through the list
// memory, one word per cycle. Search reads the list one word per cycle
// until the first match at 1-based position p or to the end. A new
// request is taken the cycle after the result is loaded.
// A result held in the output register under i_stall does not block the
// next request; only the following result waits for the output to drain.
// Reset empties the list (count zero) and drops any pending result; the
// word memory itself is not cleared.
`default_nettype none

module indexed_list_table #(
    parameter int DEPTH = ilt_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [ilt_pkg::ACT_W-1:0]         i_action,
    input  wire logic [ilt_pkg::IDX_W-1:0]         i_index,
    input  wire logic signed [ilt_pkg::DATA_W-1:0] i_value,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [ilt_pkg::STAT_W-1:0]        o_status,
    output logic      [ilt_pkg::POS_W-1:0]         o_position,
    output logic      [ilt_pkg::POS_W-1:0]         o_length
);

    ilt_pkg::t_cmd cmd;
    ilt_pkg::t_sts sts;

    ilt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ilt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_length    (o_length)
    );

endmodule

`default_nettype wire
